### rtl/wfmm_pkg.sv
package wfmm_pkg;

    localparam int MAX_CHANNELS = 8;
    localparam int CH_W         = 3;
    localparam int PEAK_W       = 16;
    localparam int SAMPLE_W     = 32;
    localparam int BITS_W       = 6;
    localparam int FRAMES_W     = 20;
    localparam int POINT_W      = 32;
    localparam int CNT_W        = 4;
    localparam int REG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 32;

    localparam logic signed [PEAK_W-1:0] PEAK_TOP    = 16'sh7FFF;
    localparam logic signed [PEAK_W-1:0] PEAK_BOTTOM = 16'sh8000;

    localparam logic [REG_IDX_W-1:0] REG_CHANNEL_COUNT  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SAMPLE_BITS    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_BUCKET_FRAMES  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_POINT_CAPACITY = 3'd3;

    localparam logic [CNT_W-1:0]    RST_CHANNEL_COUNT  = 4'd2;
    localparam logic [BITS_W-1:0]   RST_SAMPLE_BITS    = 6'd16;
    localparam logic [FRAMES_W-1:0] RST_BUCKET_FRAMES  = 20'd480;
    localparam logic [POINT_W-1:0]  RST_POINT_CAPACITY = 32'hFFFF_FFFF;

    typedef struct packed {
        logic update;
        logic clear;
    } lane_ctrl_t;

    typedef struct packed {
        logic [MAX_CHANNELS-1:0][PEAK_W-1:0] mins;
        logic [MAX_CHANNELS-1:0][PEAK_W-1:0] maxs;
        logic [CH_W-1:0]                     last_ch;
        logic [POINT_W-1:0]                  point_index;
        logic                                partial;
    } record_t;

endpackage

### rtl/waveform_minmax_peaks_unit.sv
// A closing request's record is written into the bucket queue; its first result is then registered at the output.
// A closed bucket streams one result per active channel, one per cycle while m_ready is high.
// Throughput: one request per cycle while s_ready is high; a two-record bucket queue absorbs result bursts.
// Buckets closing faster than their results drain fill the queue, and s_ready drops until a record is popped.
// Reset is synchronous and active low: registers take their defaults, trackers clear.
module waveform_minmax_peaks_unit
    import wfmm_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [REG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_command,
    input  logic signed [SAMPLE_W-1:0] s_sample_0,
    input  logic signed [SAMPLE_W-1:0] s_sample_1,
    input  logic signed [SAMPLE_W-1:0] s_sample_2,
    input  logic signed [SAMPLE_W-1:0] s_sample_3,
    input  logic signed [SAMPLE_W-1:0] s_sample_4,
    input  logic signed [SAMPLE_W-1:0] s_sample_5,
    input  logic signed [SAMPLE_W-1:0] s_sample_6,
    input  logic signed [SAMPLE_W-1:0] s_sample_7,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [CH_W-1:0]            m_channel,
    output logic signed [PEAK_W-1:0]   m_low_peak,
    output logic signed [PEAK_W-1:0]   m_high_peak,
    output logic [POINT_W-1:0]         m_point_index,
    output logic                       m_partial,
    output logic                       m_last
);

    localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_CHANNELS);

    logic [CNT_W-1:0]    channel_count_reg;
    logic [BITS_W-1:0]   sample_bits_reg;
    logic [FRAMES_W-1:0] bucket_frames_reg;
    logic [POINT_W-1:0]  point_capacity_reg;
    logic [FRAMES_W-1:0] frames_reg;
    logic [FRAMES_W-1:0] frames_next;
    logic [POINT_W-1:0]  points_reg;
    logic [POINT_W-1:0]  points_next;

    logic signed [SAMPLE_W-1:0] samples [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0][PEAK_W-1:0] lane_min;
    logic [MAX_CHANNELS-1:0][PEAK_W-1:0] lane_max;

    logic                accept;
    logic                frame_acc;
    logic                flush_acc;
    logic                cap_hit;
    logic                update;
    logic [FRAMES_W-1:0] frames_inc;
    logic [FRAMES_W-1:0] need;
    logic                close;
    logic                flush_emit;
    logic                push;
    logic                full;
    logic [CH_W-1:0]     last_ch;
    record_t             rec;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            channel_count_reg  <= RST_CHANNEL_COUNT;
            sample_bits_reg    <= RST_SAMPLE_BITS;
            bucket_frames_reg  <= RST_BUCKET_FRAMES;
            point_capacity_reg <= RST_POINT_CAPACITY;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_CHANNEL_COUNT:  channel_count_reg  <= cfg_data[CNT_W-1:0];
                REG_SAMPLE_BITS:    sample_bits_reg    <= cfg_data[BITS_W-1:0];
                REG_BUCKET_FRAMES:  bucket_frames_reg  <= cfg_data[FRAMES_W-1:0];
                REG_POINT_CAPACITY: point_capacity_reg <= cfg_data[POINT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (channel_count_reg == '0) begin
            last_ch = '0;
        end else if (channel_count_reg > MAX_COUNT) begin
            last_ch = CH_W'(MAX_CHANNELS - 1);
        end else begin
            last_ch = CH_W'(channel_count_reg - CNT_W'(1));
        end
    end

    assign samples[0] = s_sample_0;
    assign samples[1] = s_sample_1;
    assign samples[2] = s_sample_2;
    assign samples[3] = s_sample_3;
    assign samples[4] = s_sample_4;
    assign samples[5] = s_sample_5;
    assign samples[6] = s_sample_6;
    assign samples[7] = s_sample_7;

    assign s_ready    = !full;
    assign accept     = s_valid && s_ready;
    assign frame_acc  = accept && !s_command;
    assign flush_acc  = accept && s_command;
    assign cap_hit    = (points_reg >= point_capacity_reg);
    assign update     = frame_acc && !cap_hit;
    assign frames_inc = frames_reg + FRAMES_W'(1);
    assign need       = (bucket_frames_reg == '0) ? FRAMES_W'(1) : bucket_frames_reg;
    assign close      = update && (frames_inc >= need);
    assign flush_emit = flush_acc && (frames_reg != '0) && !cap_hit;
    assign push       = close || flush_emit;

    for (genvar i = 0; i < MAX_CHANNELS; i++) begin : g_lane
        lane_ctrl_t ctrl;
        logic signed [PEAK_W-1:0] pmin;
        logic signed [PEAK_W-1:0] pmax;

        assign ctrl.update = update && (CH_W'(i) <= last_ch);
        assign ctrl.clear  = close || flush_acc;

        wfmm_lane u_lane (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .sample_bits (sample_bits_reg),
            .sample      (samples[i]),
            .peak_min    (pmin),
            .peak_max    (pmax)
        );

        assign lane_min[i] = pmin;
        assign lane_max[i] = pmax;
    end

    assign rec.mins        = lane_min;
    assign rec.maxs        = lane_max;
    assign rec.last_ch     = last_ch;
    assign rec.point_index = points_reg;
    assign rec.partial     = flush_acc;

    always_comb begin
        frames_next = frames_reg;
        points_next = points_reg;
        if (flush_acc) begin
            frames_next = '0;
            points_next = '0;
        end else if (close) begin
            frames_next = '0;
            points_next = points_reg + POINT_W'(1);
        end else if (update) begin
            frames_next = frames_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frames_reg <= '0;
            points_reg <= '0;
        end else begin
            frames_reg <= frames_next;
            points_reg <= points_next;
        end
    end

    wfmm_merge u_merge (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .push            (push),
        .rec             (rec),
        .full            (full),
        .out_valid       (m_valid),
        .out_ready       (m_ready),
        .out_channel     (m_channel),
        .out_low_peak    (m_low_peak),
        .out_high_peak   (m_high_peak),
        .out_point_index (m_point_index),
        .out_partial     (m_partial),
        .out_last        (m_last)
    );

`ifndef NO_ASSERTIONS
    // A flush always restarts the segment counters.
    assert property (@(posedge aclk) disable iff (!aresetn)
        flush_acc |=> (frames_reg == '0) && (points_reg == '0))
        else $error("segment counters not cleared by flush");

    // A frame dropped at capacity leaves the counters untouched.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (frame_acc && cap_hit) |=> $stable(frames_reg) && $stable(points_reg))
        else $error("dropped frame changed the counters");

    // A closing bucket advances the point index by exactly one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        close |=> (points_reg == $past(points_reg) + POINT_W'(1)) && (frames_reg == '0))
        else $error("bucket close did not advance the point index");

    // The bucket counter stays below the bucket size after every frame.
    assert property (@(posedge aclk) disable iff (!aresetn)
        update |=> (frames_reg < $past(need)))
        else $error("bucket counter reached the bucket size");
`endif

endmodule

### rtl/wfmm_lane.sv
module wfmm_lane
    import wfmm_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  lane_ctrl_t                 ctrl,
    input  logic [BITS_W-1:0]          sample_bits,
    input  logic signed [SAMPLE_W-1:0] sample,
    output logic signed [PEAK_W-1:0]   peak_min,
    output logic signed [PEAK_W-1:0]   peak_max
);

    localparam int WIDE_W = SAMPLE_W + PEAK_W;
    localparam logic signed [WIDE_W-1:0] TOP_WIDE    = WIDE_W'(PEAK_TOP);
    localparam logic signed [WIDE_W-1:0] BOTTOM_WIDE = -TOP_WIDE - WIDE_W'(1);
    localparam logic [BITS_W-1:0] NATIVE_BITS = BITS_W'(PEAK_W);

    logic signed [WIDE_W-1:0] wide_sample;
    logic signed [WIDE_W-1:0] shifted;
    logic [BITS_W-1:0]        right_amt;
    logic [BITS_W-1:0]        left_amt;
    logic signed [PEAK_W-1:0] scaled;
    logic signed [PEAK_W-1:0] min_reg;
    logic signed [PEAK_W-1:0] max_reg;
    logic signed [PEAK_W-1:0] min_next;
    logic signed [PEAK_W-1:0] max_next;

    assign wide_sample = WIDE_W'(sample);
    assign right_amt   = sample_bits - NATIVE_BITS;
    assign left_amt    = NATIVE_BITS - sample_bits;

    always_comb begin
        if (sample_bits > NATIVE_BITS) begin
            shifted = wide_sample >>> right_amt;
        end else begin
            shifted = wide_sample <<< left_amt;
        end
        if (shifted > TOP_WIDE) begin
            scaled = PEAK_TOP;
        end else if (shifted < BOTTOM_WIDE) begin
            scaled = PEAK_BOTTOM;
        end else begin
            scaled = shifted[PEAK_W-1:0];
        end
    end

    always_comb begin
        min_next = min_reg;
        max_next = max_reg;
        if (ctrl.update) begin
            if (scaled < min_reg) begin
                min_next = scaled;
            end
            if (scaled > max_reg) begin
                max_next = scaled;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            min_reg <= PEAK_TOP;
            max_reg <= PEAK_BOTTOM;
        end else begin
            min_reg <= min_next;
            max_reg <= max_next;
        end
    end

    assign peak_min = min_next;
    assign peak_max = max_next;

endmodule

### rtl/wfmm_merge.sv
module wfmm_merge
    import wfmm_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     push,
    input  record_t                  rec,
    output logic                     full,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [CH_W-1:0]          out_channel,
    output logic signed [PEAK_W-1:0] out_low_peak,
    output logic signed [PEAK_W-1:0] out_high_peak,
    output logic [POINT_W-1:0]       out_point_index,
    output logic                     out_partial,
    output logic                     out_last
);

    localparam int DEPTH = 2;
    localparam int PTR_W = 1;
    localparam int QCNT_W = 2;
    localparam logic [QCNT_W-1:0] QCNT_FULL = QCNT_W'(DEPTH);

    record_t queue_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic [CH_W-1:0]   chan_reg;
    logic              valid_reg;
    logic [CH_W-1:0]   channel_reg;
    logic [PEAK_W-1:0] low_reg;
    logic [PEAK_W-1:0] high_reg;
    logic [POINT_W-1:0] index_reg;
    logic              partial_reg;
    logic              last_reg;

    record_t head;
    logic    out_free;
    logic    beat;
    logic    last_beat;
    logic    pop;

    assign head      = queue_reg[rd_ptr_reg];
    assign full      = (count_reg == QCNT_FULL);
    assign out_free  = !valid_reg || out_ready;
    assign beat      = out_free && (count_reg != '0);
    assign last_beat = (chan_reg == head.last_ch);
    assign pop       = beat && last_beat;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            chan_reg   <= '0;
            valid_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (beat) begin
                valid_reg <= 1'b1;
                if (last_beat) begin
                    chan_reg   <= '0;
                    rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
                end else begin
                    chan_reg <= chan_reg + CH_W'(1);
                end
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= rec;
        end
        if (beat) begin
            channel_reg <= chan_reg;
            low_reg     <= head.mins[chan_reg];
            high_reg    <= head.maxs[chan_reg];
            index_reg   <= head.point_index;
            partial_reg <= head.partial;
            last_reg    <= last_beat;
        end
    end

    assign out_valid       = valid_reg;
    assign out_channel     = channel_reg;
    assign out_low_peak    = $signed(low_reg);
    assign out_high_peak   = $signed(high_reg);
    assign out_point_index = index_reg;
    assign out_partial     = partial_reg;
    assign out_last        = last_reg;

endmodule
